FILE: design/fflb_pkg.sv
// Shared types and constants for the first-fit lifetime buffer planner.
package fflb_pkg;

    localparam int BUF_NUM_BITS = 6;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_RK_A,
        ST_RK_B,
        ST_RK_C,
        ST_PL_A,
        ST_PL_B,
        ST_PL_C,
        ST_PL_D,
        ST_PL_W,
        ST_EM_A,
        ST_EM_B,
        ST_EM_C
    } t_state;

endpackage

FILE: design/fflb_if.sv
// Request and result channel interfaces of the buffer planner.
interface fflb_req_if #(
    parameter int STEP_BITS = 12,
    parameter int SIZE_BITS = 32
);
    logic                 valid;
    logic                 ready;
    logic [STEP_BITS-1:0] first_use_step;
    logic [STEP_BITS-1:0] last_use_step;
    logic [SIZE_BITS-1:0] byte_size;
    logic                 final_record;

    modport source (output valid, first_use_step, last_use_step, byte_size, final_record,
                    input ready);
    modport sink   (input valid, first_use_step, last_use_step, byte_size, final_record,
                    output ready);
endinterface

interface fflb_rsp_if #(
    parameter int SIZE_BITS = 32
);
    logic                                 valid;
    logic                                 ready;
    logic [fflb_pkg::BUF_NUM_BITS-1:0]    buffer_number;
    logic [SIZE_BITS-1:0]                 placed_offset;
    logic [SIZE_BITS-1:0]                 arena_size;
    logic                                 final_result;

    modport source (output valid, buffer_number, placed_offset, arena_size, final_result,
                    input ready);
    modport sink   (input valid, buffer_number, placed_offset, arena_size, final_result,
                    output ready);
endinterface

FILE: design/fflb_ram.sv
// Simple dual-port synchronous RAM with registered read.
module fflb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: design/first_fit_lifetime_buffer_planner_unit.sv
// First-fit lifetime buffer planner: top level with sequencer and state memories.
//
// Usage: buffer records (first-use step, last-use step, byte size) arrive on
// the request channel i_req, one per cycle while the block is loading. A
// record with final_record set is stored like the others and starts planning.
// Records beyond MAX_BUFFERS are dropped; their final mark still plans.
// Planning ranks every buffer against all others, reading them one at a time
// through the single read port of the record memory, then places each
// buffer by repeated passes over the placed-buffer memory, one entry per
// cycle, until a full pass finds no overlap. Results then leave on o_rsp in
// load order, one at a time: the next result is read only after the last
// one is taken; arena_size and final_result come with the last one. A record
// stalls on the request side (ready low) from the final record until the last
// result is taken; a stalled receiver holds the result register and the
// sequencer. Reset returns the block to loading with an empty store; the
// memories need no clearing.
module first_fit_lifetime_buffer_planner_unit #(
    parameter int MAX_BUFFERS = 64,
    parameter int STEP_BITS   = 12,
    parameter int SIZE_BITS   = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    fflb_req_if.sink   i_req,
    fflb_rsp_if.source o_rsp
);
    localparam int IW = $clog2(MAX_BUFFERS);
    localparam int CW = IW + 1;
    localparam int OW = SIZE_BITS + IW + 1;
    localparam int RW = 2 * STEP_BITS + SIZE_BITS;
    localparam int PW = STEP_BITS + 2 * OW;

    fflb_pkg::t_state r_state, n_state;

    logic [CW-1:0]        r_cnt, n_cnt, r_n, n_n, r_clean, n_clean;
    logic [IW-1:0]        r_i, n_i, r_j, n_j, r_rank, n_rank;
    logic [IW-1:0]        r_pos, n_pos, r_cur, n_cur, r_q, n_q, r_k, n_k;
    logic [STEP_BITS-1:0] r_si, n_si, r_ei, n_ei;
    logic [SIZE_BITS-1:0] r_csize, n_csize;
    logic [OW-1:0]        r_cand, n_cand, r_cend, n_cend, r_peak, n_peak;
    logic                 r_ov, n_ov, r_ofin, n_ofin;
    logic [IW-1:0]        r_onum, n_onum;
    logic [SIZE_BITS-1:0] r_ooff, n_ooff, r_oarena, n_oarena;

    logic          rec_we, ord_we, pl_we, off_we;
    logic [IW-1:0] rec_waddr, rec_raddr, ord_waddr, ord_raddr;
    logic [IW-1:0] pl_waddr, pl_raddr, off_waddr, off_raddr;
    logic [RW-1:0] rec_wdata, rec_rdata;
    logic [IW-1:0] ord_wdata, ord_rdata;
    logic [PW-1:0] pl_wdata, pl_rdata;
    logic [OW-1:0] off_wdata, off_rdata;

    fflb_ram #(.WIDTH(RW), .DEPTH(MAX_BUFFERS)) u_rec (
        .i_clk(i_clk), .i_we(rec_we), .i_waddr(rec_waddr), .i_wdata(rec_wdata),
        .i_raddr(rec_raddr), .o_rdata(rec_rdata));
    fflb_ram #(.WIDTH(IW), .DEPTH(MAX_BUFFERS)) u_ord (
        .i_clk(i_clk), .i_we(ord_we), .i_waddr(ord_waddr), .i_wdata(ord_wdata),
        .i_raddr(ord_raddr), .o_rdata(ord_rdata));
    fflb_ram #(.WIDTH(PW), .DEPTH(MAX_BUFFERS)) u_pl (
        .i_clk(i_clk), .i_we(pl_we), .i_waddr(pl_waddr), .i_wdata(pl_wdata),
        .i_raddr(pl_raddr), .o_rdata(pl_rdata));
    fflb_ram #(.WIDTH(OW), .DEPTH(MAX_BUFFERS)) u_off (
        .i_clk(i_clk), .i_we(off_we), .i_waddr(off_waddr), .i_wdata(off_wdata),
        .i_raddr(off_raddr), .o_rdata(off_rdata));

    logic [STEP_BITS-1:0] rs, re, pe;
    logic [SIZE_BITS-1:0] rz;
    logic [OW-1:0]        pb, pend;
    logic [IW-1:0]        last, rank_nx, q_nx, pos_m1;
    logic                 goes_first, live, ovl, in_acc, out_acc;
    logic [CW-1:0]        cnt_nx;

    assign rs   = rec_rdata[RW-1 -: STEP_BITS];
    assign re   = rec_rdata[SIZE_BITS +: STEP_BITS];
    assign rz   = rec_rdata[SIZE_BITS-1:0];
    assign pe   = pl_rdata[PW-1 -: STEP_BITS];
    assign pb   = pl_rdata[OW +: OW];
    assign pend = pl_rdata[OW-1:0];
    assign last   = IW'(r_n - CW'(1));
    assign pos_m1 = r_pos - IW'(1);

    assign in_acc  = i_req.valid && i_req.ready;
    assign out_acc = o_rsp.valid && o_rsp.ready;

    assign i_req.ready         = (r_state == fflb_pkg::ST_LOAD);
    assign o_rsp.valid         = r_ov;
    assign o_rsp.buffer_number = fflb_pkg::BUF_NUM_BITS'(r_onum);
    assign o_rsp.placed_offset = r_ooff;
    assign o_rsp.arena_size    = r_oarena;
    assign o_rsp.final_result  = r_ofin;

    always_comb begin
        goes_first = (rs < r_si) ||
                     ((rs == r_si) && ((re < r_ei) || ((re == r_ei) && (r_j < r_i))));
        rank_nx = r_rank + IW'(goes_first);
        live    = (pe >= r_si);
        ovl     = live && (r_cand < pend) && (pb < r_cend) && (r_cand < r_cend) && (pb < pend);
        q_nx    = (r_q == pos_m1) ? '0 : r_q + IW'(1);
        cnt_nx  = (r_cnt < CW'(MAX_BUFFERS)) ? r_cnt + CW'(1) : r_cnt;
    end

    always_comb begin
        n_state = r_state;
        n_cnt = r_cnt; n_n = r_n; n_clean = r_clean;
        n_i = r_i; n_j = r_j; n_rank = r_rank;
        n_pos = r_pos; n_cur = r_cur; n_q = r_q; n_k = r_k;
        n_si = r_si; n_ei = r_ei; n_csize = r_csize;
        n_cand = r_cand; n_cend = r_cend; n_peak = r_peak;
        n_ov = r_ov; n_ofin = r_ofin; n_onum = r_onum; n_ooff = r_ooff; n_oarena = r_oarena;
        rec_we = 1'b0; rec_waddr = r_cnt[IW-1:0];
        rec_wdata = {i_req.first_use_step, i_req.last_use_step, i_req.byte_size};
        rec_raddr = r_i;
        ord_we = 1'b0; ord_waddr = rank_nx; ord_wdata = r_i; ord_raddr = r_pos;
        pl_we = 1'b0; pl_waddr = r_pos; pl_wdata = {r_ei, r_cand, r_cend}; pl_raddr = r_q;
        off_we = 1'b0; off_waddr = r_cur; off_wdata = r_cand; off_raddr = r_k;
        unique case (r_state)
            fflb_pkg::ST_LOAD: begin
                if (in_acc) begin
                    rec_we = (r_cnt < CW'(MAX_BUFFERS));
                    n_cnt  = cnt_nx;
                    if (i_req.final_record) begin
                        n_n     = cnt_nx;
                        n_i     = '0;
                        n_state = fflb_pkg::ST_RK_A;
                    end
                end
            end
            fflb_pkg::ST_RK_A: begin
                rec_raddr = r_i;
                n_state   = fflb_pkg::ST_RK_B;
            end
            fflb_pkg::ST_RK_B: begin
                n_si      = rs;
                n_ei      = re;
                n_j       = '0;
                n_rank    = '0;
                rec_raddr = '0;
                n_state   = fflb_pkg::ST_RK_C;
            end
            fflb_pkg::ST_RK_C: begin
                rec_raddr = r_j + IW'(1);
                n_j       = r_j + IW'(1);
                n_rank    = rank_nx;
                if (r_j == last) begin
                    ord_we = 1'b1;
                    if (r_i == last) begin
                        n_pos   = '0;
                        n_peak  = '0;
                        n_state = fflb_pkg::ST_PL_A;
                    end else begin
                        n_i     = r_i + IW'(1);
                        n_state = fflb_pkg::ST_RK_A;
                    end
                end
            end
            fflb_pkg::ST_PL_A: begin
                ord_raddr = r_pos;
                n_state   = fflb_pkg::ST_PL_B;
            end
            fflb_pkg::ST_PL_B: begin
                n_cur     = ord_rdata;
                rec_raddr = ord_rdata;
                n_state   = fflb_pkg::ST_PL_C;
            end
            fflb_pkg::ST_PL_C: begin
                n_si     = rs;
                n_ei     = re;
                n_csize  = rz;
                n_cand   = '0;
                n_cend   = OW'(rz);
                n_q      = '0;
                n_clean  = '0;
                pl_raddr = '0;
                n_state  = (r_pos == '0) ? fflb_pkg::ST_PL_W : fflb_pkg::ST_PL_D;
            end
            fflb_pkg::ST_PL_D: begin
                pl_raddr = q_nx;
                n_q      = q_nx;
                if (ovl) begin
                    n_cand  = pend;
                    n_cend  = pend + OW'(r_csize);
                    n_clean = '0;
                end else begin
                    n_clean = r_clean + CW'(1);
                    if (r_clean + CW'(1) == {1'b0, r_pos}) begin
                        n_state = fflb_pkg::ST_PL_W;
                    end
                end
            end
            fflb_pkg::ST_PL_W: begin
                pl_we  = 1'b1;
                off_we = 1'b1;
                if (r_cend > r_peak) begin
                    n_peak = r_cend;
                end
                if (r_pos == last) begin
                    n_k     = '0;
                    n_state = fflb_pkg::ST_EM_A;
                end else begin
                    n_pos   = r_pos + IW'(1);
                    n_state = fflb_pkg::ST_PL_A;
                end
            end
            fflb_pkg::ST_EM_A: begin
                off_raddr = r_k;
                n_state   = fflb_pkg::ST_EM_B;
            end
            fflb_pkg::ST_EM_B: begin
                n_ov   = 1'b1;
                n_onum = r_k;
                n_ooff = (|off_rdata[OW-1:SIZE_BITS]) ? '1 : off_rdata[SIZE_BITS-1:0];
                n_ofin = (r_k == last);
                if (r_k == last) begin
                    n_oarena = (|r_peak[OW-1:SIZE_BITS]) ? '1 : r_peak[SIZE_BITS-1:0];
                end else begin
                    n_oarena = '0;
                end
                n_state = fflb_pkg::ST_EM_C;
            end
            fflb_pkg::ST_EM_C: begin
                if (out_acc) begin
                    n_ov = 1'b0;
                    if (r_ofin) begin
                        n_cnt   = '0;
                        n_state = fflb_pkg::ST_LOAD;
                    end else begin
                        n_k     = r_k + IW'(1);
                        n_state = fflb_pkg::ST_EM_A;
                    end
                end
            end
            default: n_state = fflb_pkg::ST_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fflb_pkg::ST_LOAD;
            r_cnt   <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_n <= n_n; r_clean <= n_clean;
        r_i <= n_i; r_j <= n_j; r_rank <= n_rank;
        r_pos <= n_pos; r_cur <= n_cur; r_q <= n_q; r_k <= n_k;
        r_si <= n_si; r_ei <= n_ei; r_csize <= n_csize;
        r_cand <= n_cand; r_cend <= n_cend; r_peak <= n_peak;
        r_ofin <= n_ofin; r_onum <= n_onum; r_ooff <= n_ooff; r_oarena <= n_oarena;
    end
endmodule

FILE: design/fflb_checker.sv
// Port-level checker for the buffer planner and its bind statement.
module fflb_checker #(
    parameter int SIZE_BITS = 32
) (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 i_in_valid,
    input logic                                 i_in_ready,
    input logic                                 i_out_valid,
    input logic                                 i_out_ready,
    input logic [fflb_pkg::BUF_NUM_BITS-1:0]    i_out_num,
    input logic [SIZE_BITS-1:0]                 i_out_arena,
    input logic                                 i_out_final
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_num))
        else $error("result dropped or changed while stalled");

    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_in_ready && i_out_valid))
        else $error("loading while results pending");

    a_reload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && i_out_final |=> i_in_ready)
        else $error("not loading after last result");

    a_arena: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_final |-> i_out_arena == '0)
        else $error("arena size on a non-final result");

    a_req_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !i_in_ready |=> i_in_valid)
        else $error("request withdrawn while stalled");
endmodule

bind first_fit_lifetime_buffer_planner_unit fflb_checker #(.SIZE_BITS(SIZE_BITS)) u_fflb_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_req.valid),
    .i_in_ready  (i_req.ready),
    .i_out_valid (o_rsp.valid),
    .i_out_ready (o_rsp.ready),
    .i_out_num   (o_rsp.buffer_number),
    .i_out_arena (o_rsp.arena_size),
    .i_out_final (o_rsp.final_result)
);
